FILE: design/command_line_assembler_unit_assert.svh
// ----------------------------------------------------------------------------
// command line assembler assertion macros
// shared property wrappers, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`define COMMAND_LINE_ASSEMBLER_UNIT_ASSERT_SVH

// property that must hold at every edge out of reset
`define CLA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("command line assembler check failed");

// implication from a trigger to a consequence in the same cycle
`define CLA_ASSERT_IMP(lbl, clk, rst_n, trig, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("command line assembler implication failed");

`endif

FILE: design/cla_pkg.sv
// ----------------------------------------------------------------------------
// cla_pkg
// shared types, codes and sizes of the command line assembler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cla_pkg;

	// line store size
	localparam int LINE_DEPTH = 32;
	localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// character codes
	localparam logic [7:0] CODE_CR        = 8'h0D;
	localparam logic [7:0] PRINT_LOW      = 8'h20;
	localparam logic [7:0] PRINT_HIGH     = 8'h7E;
	localparam logic [7:0] ESCAPE_RESET   = 8'd27;
	localparam logic [7:0] BACKSPACE_RESET = 8'd8;

	// register indexes
	localparam logic REG_ESCAPE    = 1'b0;
	localparam logic REG_BACKSPACE = 1'b1;

	typedef enum logic [1:0] {
		KIND_CHAR  = 2'd0,
		KIND_EOL   = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RD,
		ST_WR,
		ST_EOL
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  capture;
		logic  clear_cnt;
		logic  dec_cnt;
		logic  append;
		logic  rd_start;
		logic  rd_next;
		logic  load_out;
		kind_t out_kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic is_esc;
		logic is_bs;
		logic is_print;
		logic is_cr;
		logic empty;
		logic rd_last;
		logic slot_free;
	} status_t;

endpackage

FILE: design/command_line_assembler_unit.sv
// ----------------------------------------------------------------------------
// command_line_assembler_unit
// collects received words into a command line with backspace and escape
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         rx_byte in tdata
//  m_axis    out        line_char in tdata, kind in tuser, last in tlast
//  cfg       in         register index and write data
//
//  a byte that only edits the line is accepted, then evaluated
//  an error is evaluated and loaded once the output register is free
//  a carriage return reads each stored character through the
//  registered read port of the line store (address, then data)
//  a new word is taken while the last result still waits in the output register
//  reset clears the count and sets the code registers to their defaults; the store itself is not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_line_assembler_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] line_char
	output logic [1:0] m_axis_tuser,   // [1:0] kind
	output logic       m_axis_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	import cla_pkg::*;

	cmd_t    cmd;
	status_t st;

	assign cfg_ready = 1'b1;

	// sequencer
	cla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath
	cla_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.rx_byte   (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

FILE: design/cla_ctrl.sv
// ----------------------------------------------------------------------------
// cla_ctrl
// sequencer: takes one word, classifies it, and for a carriage return drives the line readout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cla_pkg::status_t  st,
	output cla_pkg::cmd_t     cmd
);
	import cla_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (st.full || st.is_esc) begin
					if (st.slot_free) state_d = ST_IDLE;
				end else if (st.is_bs || st.is_print) begin
					state_d = ST_IDLE;
				end else if (st.is_cr) begin
					state_d = st.empty ? ST_EOL : ST_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (st.slot_free) state_d = st.rd_last ? ST_EOL : ST_RD;
			end
			ST_EOL: begin
				if (st.slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.out_kind = KIND_CHAR;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EVAL: begin
				if (st.full || st.is_esc) begin
					if (st.slot_free) begin
						cmd.clear_cnt = 1'b1;
						cmd.load_out  = 1'b1;
						cmd.out_kind  = KIND_ERROR;
					end
				end else if (st.is_bs) begin
					cmd.dec_cnt = !st.empty;
				end else if (st.is_print) begin
					cmd.append = 1'b1;
				end else if (st.is_cr) begin
					cmd.rd_start = 1'b1;
				end
			end
			ST_RD: begin
			end
			ST_WR: begin
				if (st.slot_free) begin
					cmd.load_out = 1'b1;
					cmd.rd_next  = 1'b1;
					cmd.out_kind = KIND_CHAR;
				end
			end
			ST_EOL: begin
				if (st.slot_free) begin
					cmd.load_out  = 1'b1;
					cmd.clear_cnt = 1'b1;
					cmd.out_kind  = KIND_EOL;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/cla_dp.sv
// ----------------------------------------------------------------------------
// cla_dp
// line store, character count, code registers and the output word register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "command_line_assembler_unit_assert.svh"

module cla_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cla_pkg::cmd_t         cmd,
	output cla_pkg::status_t      st,
	input  logic [7:0]            rx_byte,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [7:0]            cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            out_kind,
	output logic [7:0]            out_char,
	output logic                  out_last
);
	import cla_pkg::*;

	logic [7:0]       mem_q [LINE_DEPTH];
	logic [7:0]       rd_data_q;
	logic [7:0]       rx_q;
	logic [7:0]       esc_q;
	logic [7:0]       bs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             out_valid_q;
	kind_t            kind_q;
	logic [7:0]       char_q;
	logic             last_q;

	// code registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESCAPE_RESET;
			bs_q  <= BACKSPACE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ESCAPE:    esc_q <= cfg_data;
				REG_BACKSPACE: bs_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// received word
	always_ff @(posedge clk) begin
		if (cmd.capture) rx_q <= rx_byte;
	end

	// character count, clear wins over backspace over append
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clear_cnt) begin
			cnt_q <= '0;
		end else if (cmd.dec_cnt) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.append) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// readout index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_start) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_next) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	// line store write port
	always_ff @(posedge clk) begin
		if (cmd.append) mem_q[cnt_q[IDX_W-1:0]] <= rx_q;
	end

	// line store registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_idx_q[IDX_W-1:0]];
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			kind_q <= cmd.out_kind;
			case (cmd.out_kind)
				KIND_CHAR: begin
					char_q <= rd_data_q;
					last_q <= 1'b0;
				end
				default: begin
					char_q <= 8'd0;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	// status back to the sequencer
	always_comb begin
		st.full      = (cnt_q >= CNT_W'(LINE_DEPTH));
		st.is_esc    = (rx_q == esc_q);
		st.is_bs     = (rx_q == bs_q);
		st.is_print  = (rx_q >= PRINT_LOW) && (rx_q <= PRINT_HIGH);
		st.is_cr     = (rx_q == CODE_CR);
		st.empty     = (cnt_q == '0);
		st.rd_last   = (CNT_W'(rd_idx_q + 1'b1) == cnt_q);
		st.slot_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	// count never runs past the store
	`CLA_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(LINE_DEPTH))
	// a result is loaded only into a free output slot
	`CLA_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || out_ready)
	// append only below a full store
	`CLA_ASSERT_IMP(a_append_room, clk, arst_n, cmd.append, cnt_q < CNT_W'(LINE_DEPTH))
	// readout never reads beyond the stored characters
	`CLA_ASSERT_IMP(a_rd_range, clk, arst_n, cmd.rd_next, rd_idx_q < cnt_q)

endmodule
